// ----- sv/holc_pkg.sv -----
// ----------------------------------------------------------------------------
// holc_pkg
// Shared types and constants for the header option list checker.
// ----------------------------------------------------------------------------
package holc_pkg;

  localparam int unsigned MAX_HEADER_LEN_DEF = 60;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned START_W = 6;
  localparam int unsigned CFG_W   = 6;
  localparam int unsigned CIDX_W  = 2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_CORRUPT_MODE  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_HEADER_KIND   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_OPTIONS_START = 2'd2;

  localparam logic [START_W-1:0] OPTIONS_START_RST = 6'd20;

  // header kinds
  localparam logic KIND_IP  = 1'b0;
  localparam logic KIND_TCP = 1'b1;

  // option codes
  localparam logic [BYTE_W-1:0] OPT_EOL       = 8'd0;
  localparam logic [BYTE_W-1:0] OPT_NOP       = 8'd1;
  localparam logic [BYTE_W-1:0] OPT_MIN_LEN   = 8'd2;
  localparam logic [BYTE_W-1:0] IP_RR         = 8'd7;
  localparam logic [BYTE_W-1:0] IP_TS         = 8'd68;
  localparam logic [BYTE_W-1:0] IP_SEC        = 8'd130;
  localparam logic [BYTE_W-1:0] IP_CIPSO      = 8'd134;
  localparam logic [BYTE_W-1:0] IP_SID        = 8'd136;
  localparam logic [BYTE_W-1:0] TCP_MSS       = 8'd2;
  localparam logic [BYTE_W-1:0] TCP_SACK      = 8'd5;

  typedef enum logic [2:0] {
    PH_TYPE = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  typedef struct packed {
    logic                  corrupt_mode;
    logic                  header_kind;
    logic [START_W-1:0]    options_start;
  } cfg_t;

  typedef struct packed {
    phase_t                phase;
    logic [BYTE_W-1:0]     skip;
    logic                  rejected;
    logic                  ts;
    logic                  rr;
  } walk_t;

  typedef struct packed {
    logic [BYTE_W-1:0]     data;
    logic                  last;
    logic                  accept;
    logic                  ts;
    logic                  rr;
  } result_t;

  function automatic logic is_forbidden(logic kind, logic [BYTE_W-1:0] code);
    if (kind == KIND_IP) begin
      return (code == IP_SEC) || (code == IP_CIPSO) || (code == IP_SID);
    end
    return (code >= TCP_MSS) && (code <= TCP_SACK);
  endfunction

endpackage

// ----- sv/holc_walker.sv -----
// ----------------------------------------------------------------------------
// holc_walker
// Per-byte step of the option list walk: next walk state and the result.
// ----------------------------------------------------------------------------
module holc_walker (
  input  holc_pkg::cfg_t                 cfg,
  input  holc_pkg::walk_t                walk,
  input  logic                           in_options,
  input  logic                           too_long,
  input  logic [holc_pkg::BYTE_W-1:0]    byte_in,
  input  logic                           last_in,
  output holc_pkg::walk_t                walk_nxt,
  output holc_pkg::result_t              result
);
  import holc_pkg::*;

  walk_t             step;
  logic [BYTE_W-1:0] ob;
  logic [BYTE_W-1:0] skip_dec;
  logic              open_option;

  assign skip_dec = walk.skip - 8'd1;

  always_comb begin
    step = walk;
    ob   = byte_in;
    if (too_long) begin
      step.rejected = 1'b1;
    end else if (in_options && !walk.rejected) begin
      unique case (walk.phase)
        PH_LEN: begin
          if (byte_in < OPT_MIN_LEN) begin
            step.rejected = 1'b1;
          end else begin
            step.skip  = byte_in - OPT_MIN_LEN;
            step.phase = (byte_in == OPT_MIN_LEN) ? PH_TYPE : PH_BODY;
          end
        end
        PH_BODY: begin
          step.skip = skip_dec;
          if (skip_dec == '0) begin
            step.phase = PH_TYPE;
          end
        end
        default: begin
          step.phase = PH_TYPE;
          if (byte_in == OPT_EOL) begin
            if (cfg.corrupt_mode) begin
              ob = OPT_NOP;
            end
          end else if (byte_in != OPT_NOP) begin
            if (cfg.header_kind == KIND_IP && byte_in == IP_TS) begin
              step.ts = 1'b1;
            end
            if (cfg.header_kind == KIND_IP && byte_in == IP_RR) begin
              step.rr = 1'b1;
            end
            if (is_forbidden(cfg.header_kind, byte_in) && !cfg.corrupt_mode) begin
              step.rejected = 1'b1;
            end else begin
              step.phase = PH_LEN;
            end
          end
        end
      endcase
    end

    // option still open when the header ends
    open_option = (step.phase == PH_LEN) || (step.phase == PH_BODY && step.skip != '0);
    if (last_in && !step.rejected && open_option) begin
      step.rejected = 1'b1;
    end

    result.data   = ob;
    result.last   = last_in;
    result.accept = last_in & ~step.rejected;
    result.ts     = last_in & step.ts;
    result.rr     = last_in & step.rr;

    if (last_in) begin
      walk_nxt = '{phase: PH_TYPE, skip: '0, rejected: 1'b0, ts: 1'b0, rr: 1'b0};
    end else begin
      walk_nxt = step;
    end
  end

endmodule

// ----- sv/header_option_list_checker.sv -----
// ----------------------------------------------------------------------------
// header_option_list_checker
// Walks the IPv4 or TCP option list of a byte-serial header and gives a verdict.
// ----------------------------------------------------------------------------
// One header byte is taken per request, and one result comes back per request
// through a single output register. A new byte is taken in any
// cycle where that register is empty or its result is taken in the same cycle,
// so throughput is one byte per clock while the result side keeps up. While a
// result waits to be taken, in_ready is low and the input stalls. The verdict,
// timestamp and record-route flags are valid on the result that carries
// out_last. Configuration is written through cfg_we/cfg_index/cfg_wdata; the
// user must do so while no header is in flight, as the block does not enforce it.
module header_option_list_checker #(
  parameter int unsigned MAX_HEADER_LEN = holc_pkg::MAX_HEADER_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [holc_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [holc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [holc_pkg::BYTE_W-1:0]    in_header_byte,
  input  logic                           in_end_of_header,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [holc_pkg::BYTE_W-1:0]    out_byte,
  output logic                           out_last,
  output logic                           out_injection_possible,
  output logic                           out_saw_timestamp,
  output logic                           out_saw_record_route
);
  import holc_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_HEADER_LEN + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_HEADER_LEN);

  cfg_t              cfg_r;
  walk_t             walk_r;
  walk_t             walk_nxt;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  result_t           res_nxt;
  result_t           res_r;
  logic              out_valid_r;
  logic              in_fire;
  logic              too_long;
  logic              in_options;

  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  assign too_long   = (pos_r >= POS_MAX);
  assign in_options = ({{(POS_W + START_W){1'b0}}, pos_r} >=
                       {{POS_W{1'b0}}, {POS_W{1'b0}}, cfg_r.options_start});

  holc_walker u_walker (
    .cfg        (cfg_r),
    .walk       (walk_r),
    .in_options (in_options),
    .too_long   (too_long),
    .byte_in    (in_header_byte),
    .last_in    (in_end_of_header),
    .walk_nxt   (walk_nxt),
    .result     (res_nxt)
  );

  // position saturates at the maximum header length
  always_comb begin
    pos_nxt = pos_r;
    if (in_end_of_header) begin
      pos_nxt = '0;
    end else if (!too_long) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{corrupt_mode: 1'b0, header_kind: KIND_IP, options_start: OPTIONS_START_RST};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CORRUPT_MODE:  cfg_r.corrupt_mode  <= cfg_wdata[0];
        CFG_HEADER_KIND:   cfg_r.header_kind   <= cfg_wdata[0];
        CFG_OPTIONS_START: cfg_r.options_start <= cfg_wdata[START_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r      <= '{phase: PH_TYPE, skip: '0, rejected: 1'b0, ts: 1'b0, rr: 1'b0};
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        walk_r <= walk_nxt;
        pos_r  <= pos_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_byte               = res_r.data;
  assign out_last               = res_r.last;
  assign out_injection_possible = res_r.accept;
  assign out_saw_timestamp      = res_r.ts;
  assign out_saw_record_route   = res_r.rr;

endmodule

// ----- tb/header_option_list_checker_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// header_option_list_checker_tb
// Self-checking bench for the IPv4/TCP header option list checker: a short
// directed table, then random headers under several register settings and
// idle patterns, each result checked against an in-bench option walk.
// ----------------------------------------------------------------------------
module header_option_list_checker_tb;
  import holc_pkg::*;

  localparam int HDR_MAX      = MAX_HEADER_LEN_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_BYTES  = 155;
  localparam int MAX_REPORTS  = 10;
  localparam int DIR_ROWS     = 24;

  typedef struct packed {
    logic              corrupt;
    logic              kind;
    logic [START_W-1:0] start;
    logic [BYTE_W-1:0] hbyte;
    logic              eoh;
    logic              typed;
    result_t           res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [BYTE_W-1:0] in_header_byte = '0;
  logic in_end_of_header = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic out_last;
  logic out_injection_possible;
  logic out_saw_timestamp;
  logic out_saw_record_route;

  // register copies and option walk state
  logic cfg_corrupt = 1'b0;
  logic cfg_kind = KIND_IP;
  logic [START_W-1:0] cfg_start = OPTIONS_START_RST;
  int walk_pos = 0;
  phase_t walk_phase = PH_TYPE;
  logic [BYTE_W-1:0] skip_left = '0;
  logic walk_rejected = 1'b0;
  logic walk_ts = 1'b0;
  logic walk_rr = 1'b0;

  result_t pending_results[$];
  logic [BYTE_W-1:0] hdr_bytes[$];

  int mismatch_cnt = 0;
  int bytes_sent = 0;
  int headers_sent = 0;
  int accepted_cnt = 0;
  int rejected_cnt = 0;
  int cycle_cnt = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int hold_left = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{1'b0, KIND_IP, 6'd20, OPT_EOL, 1'b1, 1'b1, '{OPT_EOL, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{1'b0, KIND_IP, 6'd20, 8'hFF, 1'b0, 1'b0, '0},
    '{1'b0, KIND_IP, 6'd20, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{1'b0, KIND_IP, 6'd0, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{1'b0, KIND_IP, 6'd0, IP_SEC, 1'b1, 1'b1, '{IP_SEC, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{1'b0, KIND_IP, 6'd0, IP_TS, 1'b0, 1'b0, '0},
    '{1'b0, KIND_IP, 6'd0, 8'h01, 1'b1, 1'b1, '{8'h01, 1'b1, 1'b0, 1'b1, 1'b0}},
    '{1'b0, KIND_IP, 6'd0, IP_RR, 1'b0, 1'b0, '0},
    '{1'b0, KIND_IP, 6'd0, 8'h05, 1'b0, 1'b0, '0},
    '{1'b0, KIND_IP, 6'd0, 8'hAA, 1'b0, 1'b0, '0},
    '{1'b0, KIND_IP, 6'd0, 8'h55, 1'b1, 1'b1, '{8'h55, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{1'b0, KIND_IP, 6'd0, OPT_NOP, 1'b0, 1'b0, '0},
    '{1'b0, KIND_IP, 6'd0, OPT_EOL, 1'b1, 1'b0, '0},
    '{1'b1, KIND_IP, 6'd0, OPT_EOL, 1'b1, 1'b1, '{OPT_NOP, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{1'b1, KIND_IP, 6'd0, IP_SID, 1'b0, 1'b0, '0},
    '{1'b1, KIND_IP, 6'd0, OPT_MIN_LEN, 1'b1, 1'b0, '0},
    '{1'b0, KIND_TCP, 6'd0, TCP_MSS, 1'b1, 1'b1, '{TCP_MSS, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{1'b0, KIND_TCP, 6'd0, 8'd8, 1'b0, 1'b0, '0},
    '{1'b0, KIND_TCP, 6'd0, 8'd3, 1'b0, 1'b0, '0},
    '{1'b0, KIND_TCP, 6'd0, 8'hC3, 1'b0, 1'b0, '0},
    '{1'b0, KIND_TCP, 6'd0, IP_TS, 1'b0, 1'b0, '0},
    '{1'b0, KIND_TCP, 6'd0, OPT_MIN_LEN, 1'b1, 1'b0, '0},
    '{1'b1, KIND_TCP, 6'd0, TCP_SACK, 1'b0, 1'b0, '0},
    '{1'b1, KIND_TCP, 6'd0, OPT_MIN_LEN, 1'b1, 1'b0, '0}
  };

  header_option_list_checker u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_header_byte         (in_header_byte),
    .in_end_of_header       (in_end_of_header),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_byte               (out_byte),
    .out_last               (out_last),
    .out_injection_possible (out_injection_possible),
    .out_saw_timestamp      (out_saw_timestamp),
    .out_saw_record_route   (out_saw_record_route)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // one header byte through the option walk, returns the result it should give
  function automatic result_t option_walk(logic [BYTE_W-1:0] b, logic eoh);
    result_t r;
    logic [BYTE_W-1:0] ob;
    logic banned;
    ob = b;
    banned = (cfg_kind == KIND_IP) ? (b == IP_SEC || b == IP_CIPSO || b == IP_SID)
                                   : (b >= TCP_MSS && b <= TCP_SACK);
    if (walk_pos >= HDR_MAX) begin
      walk_rejected = 1'b1;
    end else if (walk_pos >= cfg_start && !walk_rejected) begin
      case (walk_phase)
        PH_LEN: begin
          if (b < OPT_MIN_LEN) begin
            walk_rejected = 1'b1;
          end else begin
            skip_left = b - OPT_MIN_LEN;
            walk_phase = (skip_left != 0) ? PH_BODY : PH_TYPE;
          end
        end
        PH_BODY: begin
          skip_left = skip_left - 8'd1;
          if (skip_left == 0) walk_phase = PH_TYPE;
        end
        default: begin
          walk_phase = PH_TYPE;
          if (b == OPT_EOL) begin
            if (cfg_corrupt) ob = OPT_NOP;
          end else if (b != OPT_NOP) begin
            if (cfg_kind == KIND_IP && b == IP_TS) walk_ts = 1'b1;
            if (cfg_kind == KIND_IP && b == IP_RR) walk_rr = 1'b1;
            if (banned && !cfg_corrupt) walk_rejected = 1'b1;
            else walk_phase = PH_LEN;
          end
        end
      endcase
    end
    // option still open when the header ends
    if (eoh && !walk_rejected &&
        (walk_phase == PH_LEN || (walk_phase == PH_BODY && skip_left != 0)))
      walk_rejected = 1'b1;
    r.data   = ob;
    r.last   = eoh;
    r.accept = eoh & ~walk_rejected;
    r.ts     = eoh & walk_ts;
    r.rr     = eoh & walk_rr;
    if (eoh) begin
      walk_pos = 0;
      walk_phase = PH_TYPE;
      skip_left = '0;
      walk_rejected = 1'b0;
      walk_ts = 1'b0;
      walk_rr = 1'b0;
    end else if (walk_pos < HDR_MAX) begin
      walk_pos++;
    end
    return r;
  endfunction

  task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic eoh,
                            input logic typed, input result_t typed_res);
    result_t r;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_header_byte <= b;
    in_end_of_header <= eoh;
    do @(posedge clk); while (!in_ready);
    r = option_walk(b, eoh);
    pending_results.push_back(typed ? typed_res : r);
    bytes_sent++;
    if (eoh) headers_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_config(input logic corrupt, input logic kind,
                              input logic [START_W-1:0] start);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CORRUPT_MODE;
    cfg_wdata <= CFG_W'(corrupt);
    @(posedge clk);
    cfg_index <= CFG_HEADER_KIND;
    cfg_wdata <= CFG_W'(kind);
    @(posedge clk);
    cfg_index <= CFG_OPTIONS_START;
    cfg_wdata <= start;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_corrupt = corrupt;
    cfg_kind = kind;
    cfg_start = start;
  endtask

  task automatic build_header();
    int form;
    int limit;
    int room;
    int olen;
    int bad;
    logic [BYTE_W-1:0] code;
    hdr_bytes.delete();
    form = $urandom_range(0, 19);
    if (form == 0) begin
      repeat (cfg_start + $urandom_range(1, 20)) hdr_bytes.push_back(8'($urandom));
    end else if (form == 1) begin
      // ends before the option list
      repeat ($urandom_range(1, (cfg_start > 1) ? cfg_start : 1))
        hdr_bytes.push_back(8'($urandom));
    end else if (form == 2) begin
      repeat ($urandom_range(HDR_MAX + 1, HDR_MAX + 6)) hdr_bytes.push_back(8'($urandom));
    end else begin
      repeat (cfg_start) hdr_bytes.push_back(8'($urandom));
      limit = cfg_start + $urandom_range(1, 40);
      if (limit > HDR_MAX) limit = (cfg_start >= HDR_MAX) ? cfg_start + 1 : HDR_MAX;
      while (hdr_bytes.size() < limit) begin
        room = limit - hdr_bytes.size();
        case ($urandom_range(0, 9))
          0: code = OPT_EOL;
          1: code = OPT_NOP;
          2: code = IP_TS;
          3: code = IP_RR;
          4: begin
            case ($urandom_range(0, 3))
              0: code = IP_SEC;
              1: code = IP_CIPSO;
              2: code = IP_SID;
              default: code = 8'($urandom_range(TCP_MSS, TCP_SACK));
            endcase
          end
          default: code = 8'($urandom_range(2, 255));
        endcase
        if (room < 2 && code > OPT_NOP) code = OPT_NOP;
        hdr_bytes.push_back(code);
        if (code > OPT_NOP) begin
          bad = $urandom_range(0, 15);
          if (bad == 0) begin
            hdr_bytes.push_back(8'($urandom_range(0, 1)));
          end else if (bad == 1) begin
            hdr_bytes.push_back(8'hFF);
          end else begin
            olen = $urandom_range(2, (room < 12) ? room : 12);
            hdr_bytes.push_back(8'(olen));
            repeat (olen - 2) hdr_bytes.push_back(8'($urandom));
          end
        end
      end
      // cut short inside the last option
      if (form == 3 && hdr_bytes.size() > 1)
        repeat ($urandom_range(1, (hdr_bytes.size() > 3) ? 3 : hdr_bytes.size() - 1))
          void'(hdr_bytes.pop_back());
    end
  endtask

  task automatic send_header();
    foreach (hdr_bytes[i]) offer_byte(hdr_bytes[i], i == hdr_bytes.size() - 1, 1'b0, '0);
  endtask

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_byte, out_last, out_injection_possible, out_saw_timestamp,
              out_saw_record_route};
      if (got.last) begin
        if (got.accept) accepted_cnt++;
        else rejected_cnt++;
      end
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result: byte %02h last %0b accept %0b ts %0b rr %0b",
                   got.data, got.last, got.accept, got.ts, got.rr);
      end else begin
        want = pending_results.pop_front();
        if (got.data !== want.data || got.last !== want.last ||
            got.accept !== want.accept || got.ts !== want.ts || got.rr !== want.rr) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display({"mismatch: expected byte %02h last %0b accept %0b ts %0b rr %0b,",
                      " got byte %02h last %0b accept %0b ts %0b rr %0b"},
                     want.data, want.last, want.accept, want.ts, want.rr,
                     got.data, got.last, got.accept, got.ts, got.rr);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int mark;
    logic n_corrupt;
    logic n_kind;
    logic [START_W-1:0] n_start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].corrupt != cfg_corrupt || dir_rows[i].kind != cfg_kind ||
          dir_rows[i].start != cfg_start) begin
        wait_drain();
        write_config(dir_rows[i].corrupt, dir_rows[i].kind, dir_rows[i].start);
      end
      offer_byte(dir_rows[i].hbyte, dir_rows[i].eoh, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin n_corrupt = 1'b0; n_kind = KIND_IP;  n_start = OPTIONS_START_RST; end
        1: begin n_corrupt = 1'b1; n_kind = KIND_IP;  n_start = 6'd0; end
        2: begin n_corrupt = 1'b0; n_kind = KIND_TCP; n_start = 6'd20; end
        3: begin n_corrupt = 1'b1; n_kind = KIND_TCP; n_start = 6'd60; end
        4: begin n_corrupt = 1'b0; n_kind = KIND_IP;  n_start = 6'd60; end
        5: begin n_corrupt = 1'b1; n_kind = KIND_IP;  n_start = 6'd8; end
        default: begin
          n_corrupt = 1'($urandom_range(0, 1));
          n_kind = 1'($urandom_range(0, 1));
          n_start = 6'($urandom_range(0, 24));
        end
      endcase
      wait_drain();
      write_config(n_corrupt, n_kind, n_start);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0; end
        1: begin tx_idle_pct = 67; rx_stall_pct <= 0; end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 67; end
        default: begin tx_idle_pct = 14; rx_stall_pct <= 14; end
      endcase
      mark = bytes_sent;
      while (bytes_sent - mark < PHASE_BYTES) begin
        build_header();
        send_header();
        // long output hold-off while requests keep coming
        if (p == 0 && bytes_sent - mark < 40) hold_req <= ~hold_req;
        // sender waits for the block to empty after each of the early headers
        if (p == 5 && bytes_sent - mark < 40) wait_drain();
      end
    end

    wait_drain();
    repeat (5) @(posedge clk);
    $display("run covered %0d header bytes in %0d headers over 8 register settings",
             bytes_sent, headers_sent);
    $display("verdicts seen: %0d accepted, %0d rejected", accepted_cnt, rejected_cnt);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results never came", mismatch_cnt,
               pending_results.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
